// File: src/jsu_pkg.sv
// ----------------------------------------------------------------------------
// jsu_pkg
// Shared types and constants for the JSON string unescaper: item formats,
// result kinds, the job descriptor passed from front to back, queue status.
// ----------------------------------------------------------------------------
package jsu_pkg;

  // input item: one byte of text, or the end-of-text mark
  typedef struct packed {
    logic [7:0] in_byte;
    logic       input_end;
  } in_item_t;

  // kind of a result item
  typedef enum logic [1:0] {
    KIND_BYTE  = 2'd0,
    KIND_CLOSE = 2'd1,
    KIND_ERROR = 2'd2
  } kind_e;

  // result item
  typedef struct packed {
    logic [7:0] out_byte;
    kind_e      kind;
    logic       last_of_run;
  } out_item_t;

  // one accepted item that yields results: kind, result count (1..3) and bytes
  typedef struct packed {
    kind_e           kind;
    logic [1:0]      count;
    logic [2:0][7:0] bytes;
  } job_t;

  // queue status seen by the front and the top level
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // default number of jobs held between front and back
  localparam int unsigned QueueDepth = 2;

endpackage

// File: src/jsu_front.sv
// ----------------------------------------------------------------------------
// jsu_front
// Parser front end: accepts text bytes, tracks the string/escape/hex phase,
// gathers \u code points and turns each item into a job of 0 to 3 results.
// ----------------------------------------------------------------------------
module jsu_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  jsu_pkg::in_item_t   in_data_i,
  input  jsu_pkg::q_status_t  q_status_i,
  output logic                push_o,
  output jsu_pkg::job_t       job_o
);

  localparam logic [7:0] CharQuote     = 8'h22;
  localparam logic [7:0] CharBackslash = 8'h5C;
  localparam logic [7:0] CharSlash     = 8'h2F;
  localparam logic [7:0] CharB         = 8'h62;
  localparam logic [7:0] CharF         = 8'h66;
  localparam logic [7:0] CharN         = 8'h6E;
  localparam logic [7:0] CharR         = 8'h72;
  localparam logic [7:0] CharT         = 8'h74;
  localparam logic [7:0] CharU         = 8'h75;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_STR,
    PH_ESC,
    PH_HEX
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [15:0] cp_q, cp_d;
  logic [1:0]  hc_q, hc_d;
  logic        fire;
  logic [4:0]  hex;
  logic [15:0] cp_new;

  // hex digit value; bit 4 set when the byte is not a hex digit
  function automatic logic [4:0] hex_value(logic [7:0] c);
    logic [4:0] r;
    r = 5'h10;
    if (c inside {[8'h30 : 8'h39]}) begin
      r = {1'b0, 4'(c - 8'h30)};
    end else if (c inside {[8'h61 : 8'h66]}) begin
      r = {1'b0, 4'(c - 8'h61 + 8'd10)};
    end else if (c inside {[8'h41 : 8'h46]}) begin
      r = {1'b0, 4'(c - 8'h41 + 8'd10)};
    end
    return r;
  endfunction

  assign in_ready_o = !q_status_i.full;
  assign fire       = in_valid_i && in_ready_o;
  assign hex        = hex_value(in_data_i.in_byte);
  assign cp_new     = {cp_q[11:0], hex[3:0]};

  // next phase and job for the offered item
  always_comb begin
    phase_d = phase_q;
    cp_d    = cp_q;
    hc_d    = hc_q;
    push_o  = 1'b0;
    job_o   = '0;
    job_o.kind  = jsu_pkg::KIND_BYTE;
    job_o.count = 2'd1;
    if (phase_q == PH_IDLE) begin
      if (!in_data_i.input_end) begin
        if (in_data_i.in_byte == CharQuote) begin
          phase_d = PH_STR;
        end else begin
          push_o     = 1'b1;
          job_o.kind = jsu_pkg::KIND_ERROR;
        end
      end
    end else if (in_data_i.input_end) begin
      push_o     = 1'b1;
      job_o.kind = jsu_pkg::KIND_ERROR;
      phase_d    = PH_IDLE;
      cp_d       = '0;
      hc_d       = '0;
    end else begin
      case (phase_q)
        PH_STR: begin
          if (in_data_i.in_byte == CharQuote) begin
            push_o     = 1'b1;
            job_o.kind = jsu_pkg::KIND_CLOSE;
            phase_d    = PH_IDLE;
          end else if (in_data_i.in_byte == CharBackslash) begin
            phase_d = PH_ESC;
          end else begin
            push_o         = 1'b1;
            job_o.bytes[0] = in_data_i.in_byte;
          end
        end
        PH_ESC: begin
          push_o  = 1'b1;
          phase_d = PH_STR;
          case (in_data_i.in_byte)
            CharQuote:     job_o.bytes[0] = CharQuote;
            CharBackslash: job_o.bytes[0] = CharBackslash;
            CharSlash:     job_o.bytes[0] = CharSlash;
            CharB:         job_o.bytes[0] = 8'h08;
            CharF:         job_o.bytes[0] = 8'h0C;
            CharN:         job_o.bytes[0] = 8'h0A;
            CharR:         job_o.bytes[0] = 8'h0D;
            CharT:         job_o.bytes[0] = 8'h09;
            CharU: begin
              push_o  = 1'b0;
              phase_d = PH_HEX;
              cp_d    = '0;
              hc_d    = '0;
            end
            default: begin
              job_o.kind = jsu_pkg::KIND_ERROR;
              phase_d    = PH_IDLE;
              cp_d       = '0;
              hc_d       = '0;
            end
          endcase
        end
        PH_HEX: begin
          if (hex[4]) begin
            push_o     = 1'b1;
            job_o.kind = jsu_pkg::KIND_ERROR;
            phase_d    = PH_IDLE;
            cp_d       = '0;
            hc_d       = '0;
          end else if (hc_q != 2'd3) begin
            cp_d = cp_new;
            hc_d = hc_q + 2'd1;
          end else begin
            // fourth digit: utf-8 encode the code point
            push_o  = 1'b1;
            phase_d = PH_STR;
            cp_d    = '0;
            hc_d    = '0;
            if (cp_new[15:7] == '0) begin
              job_o.count    = 2'd1;
              job_o.bytes[0] = cp_new[7:0];
            end else if (cp_new[15:11] == '0) begin
              job_o.count    = 2'd2;
              job_o.bytes[0] = {3'b110, cp_new[10:6]};
              job_o.bytes[1] = {2'b10, cp_new[5:0]};
            end else begin
              job_o.count    = 2'd3;
              job_o.bytes[0] = {4'b1110, cp_new[15:12]};
              job_o.bytes[1] = {2'b10, cp_new[11:6]};
              job_o.bytes[2] = {2'b10, cp_new[5:0]};
            end
          end
        end
        default: begin
          phase_d = PH_IDLE;
        end
      endcase
    end
  end

  // parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      cp_q    <= '0;
      hc_q    <= '0;
    end else if (fire) begin
      phase_q <= phase_d;
      cp_q    <= cp_d;
      hc_q    <= hc_d;
    end
  end

endmodule

// File: src/jsu_fifo.sv
// ----------------------------------------------------------------------------
// jsu_fifo
// Short job queue between the parser front end and the result expander.
// ----------------------------------------------------------------------------
module jsu_fifo #(
  parameter int unsigned Depth = jsu_pkg::QueueDepth
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  jsu_pkg::job_t      job_i,
  input  logic               pop_i,
  output jsu_pkg::job_t      job_o,
  output jsu_pkg::q_status_t status_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  jsu_pkg::job_t   entry_q [Depth];
  logic [PtrW-1:0] wptr_q, rptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign status_o.full  = (cnt_q == CntW'(Depth));
  assign status_o.empty = (cnt_q == '0);
  assign do_push        = push_i && !status_o.full;
  assign do_pop         = pop_i && !status_o.empty;
  assign job_o          = entry_q[rptr_q];

  // entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wptr_q] <= job_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= (wptr_q == PtrW'(Depth - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == PtrW'(Depth - 1)) ? '0 : rptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// File: src/jsu_back.sv
// ----------------------------------------------------------------------------
// jsu_back
// Result expander: takes jobs from the queue and sends their 1 to 3
// result items through an output register, one item per cycle unless stalled.
// ----------------------------------------------------------------------------
module jsu_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  jsu_pkg::job_t      job_i,
  input  logic               q_empty_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output jsu_pkg::out_item_t out_data_o
);

  jsu_pkg::out_item_t out_q, out_d;
  logic               out_valid_q, out_valid_d;
  jsu_pkg::job_t      job_q, job_d;
  logic [1:0]         idx_q, idx_d;
  logic               busy_q, busy_d;
  logic               adv;

  assign adv         = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // pick the next result: rest of the current job, else head of the queue
  always_comb begin
    out_d       = out_q;
    out_valid_d = out_valid_q;
    job_d       = job_q;
    idx_d       = idx_q;
    busy_d      = busy_q;
    pop_o       = 1'b0;
    if (adv) begin
      if (busy_q) begin
        out_d.out_byte    = job_q.bytes[idx_q];
        out_d.kind        = job_q.kind;
        out_d.last_of_run = (idx_q == job_q.count - 2'd1);
        out_valid_d       = 1'b1;
        idx_d             = idx_q + 2'd1;
        busy_d            = (idx_q != job_q.count - 2'd1);
      end else if (!q_empty_i) begin
        pop_o             = 1'b1;
        out_d.out_byte    = job_i.bytes[0];
        out_d.kind        = job_i.kind;
        out_d.last_of_run = (job_i.count == 2'd1);
        out_valid_d       = 1'b1;
        job_d             = job_i;
        idx_d             = 2'd1;
        busy_d            = (job_i.count != 2'd1);
      end else begin
        out_valid_d = 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    job_q <= job_d;
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      idx_q       <= '0;
      busy_q      <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      idx_q       <= idx_d;
      busy_q      <= busy_d;
    end
  end

endmodule

// File: src/json_string_unescape_utf8.sv
// ----------------------------------------------------------------------------
// json_string_unescape_utf8
// Decodes one JSON string literal per run of text bytes into a byte stream,
// with \uXXXX escapes encoded as UTF-8.
// ----------------------------------------------------------------------------
// Input items are taken at one per cycle. The front end decides each item's
// outcome in the cycle it is accepted and queues a job of up to three result
// items; the back end issues one result item per cycle from its output
// register while the output is ready, so a \u escape that expands to two
// or three bytes occupies the output for each of them. The job queue
// (QueueDepth entries) absorbs those bursts; the input stalls only when it
// is full. With the queue and the output register free, the first result
// of an item passes through the job queue and the output register, and any
// further bytes of the same item follow without a gap.
module json_string_unescape_utf8 #(
  parameter int unsigned QueueDepth = jsu_pkg::QueueDepth
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  jsu_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output jsu_pkg::out_item_t out_data_o
);

  logic               push, pop;
  jsu_pkg::job_t      job_in, job_out;
  jsu_pkg::q_status_t q_status;

  // parser front end
  jsu_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .q_status_i (q_status),
    .push_o     (push),
    .job_o      (job_in)
  );

  // job queue
  jsu_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push && in_valid_i),
    .job_i    (job_in),
    .pop_i    (pop),
    .job_o    (job_out),
    .status_o (q_status)
  );

  // result expander
  jsu_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (job_out),
    .q_empty_i   (q_status.empty),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  // close and error items carry no byte and always end their run
  a_close_err_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.kind != jsu_pkg::KIND_BYTE
    |-> out_data_o.last_of_run && out_data_o.out_byte == 8'h00)
    else $error("close or error item not last of run or byte not zero");

  // a multi-byte run continues without a gap
  a_run_no_gap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !out_data_o.last_of_run
    |=> out_valid_o && out_data_o.kind == jsu_pkg::KIND_BYTE)
    else $error("multi-byte run broken");

  // input stalls only behind a non-empty queue
  a_stall_queue : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> !q_status.empty)
    else $error("input stalled with empty queue");

endmodule

// File: bench/jsu_tb_pkg.sv
// ----------------------------------------------------------------------------
// jsu_tb_pkg
// Character codes of the JSON string syntax, shared by the stimulus and the
// checker of the unescaper testbench.
// ----------------------------------------------------------------------------
package jsu_tb_pkg;

  // delimiters and escape introducer
  localparam logic [7:0] ChQuote     = 8'h22;
  localparam logic [7:0] ChBackslash = 8'h5C;
  localparam logic [7:0] ChSlash     = 8'h2F;

  // escape letters
  localparam logic [7:0] ChLowerB = 8'h62;
  localparam logic [7:0] ChLowerF = 8'h66;
  localparam logic [7:0] ChLowerN = 8'h6E;
  localparam logic [7:0] ChLowerR = 8'h72;
  localparam logic [7:0] ChLowerT = 8'h74;
  localparam logic [7:0] ChLowerU = 8'h75;

  // hex digit ranges
  localparam logic [7:0] Ch0      = 8'h30;
  localparam logic [7:0] Ch9      = 8'h39;
  localparam logic [7:0] ChLowerA = 8'h61;
  localparam logic [7:0] ChUpperA = 8'h41;
  localparam logic [7:0] ChUpperF = 8'h46;

  // control bytes produced by the single-letter escapes
  localparam logic [7:0] ChBackspace = 8'h08;
  localparam logic [7:0] ChFormFeed  = 8'h0C;
  localparam logic [7:0] ChLineFeed  = 8'h0A;
  localparam logic [7:0] ChReturn    = 8'h0D;
  localparam logic [7:0] ChTab       = 8'h09;

  // letters that may follow a backslash and yield one byte
  localparam logic [7:0][7:0] SimpleEscapes = {
    ChQuote, ChBackslash, ChSlash, ChLowerB, ChLowerF, ChLowerN, ChLowerR, ChLowerT
  };

endpackage

// File: bench/jsu_result_checker.sv
// ----------------------------------------------------------------------------
// jsu_result_checker
// Watches both channels of the unescaper, decodes every accepted input item
// with its own copy of the string state and compares each result item,
// field by field, against the oldest outstanding decoded item.
// ----------------------------------------------------------------------------
module jsu_result_checker
  import jsu_pkg::*;
  import jsu_tb_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_ready_i,
  input  in_item_t  in_data_i,
  input  logic      out_valid_i,
  input  logic      out_ready_i,
  input  out_item_t out_data_i,
  output int        fail_count_o,
  output int        pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_STR  = 3'd1,
    PH_ESC  = 3'd2,
    PH_HEX  = 3'd3
  } phase_e;

  localparam logic [4:0] NotHex = 5'd16;

  phase_e      phase_q;
  logic [15:0] code_point_q;
  logic [1:0]  hex_count_q;
  out_item_t   decoded_q[$];
  int          fails = 0;

  // value of a hex digit in either case
  function automatic logic [4:0] hex_digit_value(logic [7:0] c);
    if (c >= Ch0 && c <= Ch9) return {1'b0, 4'(c - Ch0)};
    if (c >= ChLowerA && c <= ChLowerF) return {1'b0, 4'(c - ChLowerA + 8'd10)};
    if (c >= ChUpperA && c <= ChUpperF) return {1'b0, 4'(c - ChUpperA + 8'd10)};
    return NotHex;
  endfunction

  task automatic push_result(logic [7:0] b, kind_e k, logic last);
    out_item_t r;
    r.out_byte    = b;
    r.kind        = k;
    r.last_of_run = last;
    decoded_q.insert(decoded_q.size(), r);
  endtask

  task automatic raise_error();
    phase_q      = PH_IDLE;
    code_point_q = '0;
    hex_count_q  = '0;
    push_result(8'h00, KIND_ERROR, 1'b1);
  endtask

  task automatic escape_to(logic [7:0] b);
    phase_q = PH_STR;
    push_result(b, KIND_BYTE, 1'b1);
  endtask

  // one step of the string decoder
  task automatic decode_item(in_item_t it);
    logic [7:0]  c;
    logic [4:0]  digit;
    logic [15:0] cp;
    c = it.in_byte;
    case (phase_q)
      PH_STR: begin
        if (it.input_end) raise_error();
        else if (c == ChQuote) begin
          phase_q = PH_IDLE;
          push_result(8'h00, KIND_CLOSE, 1'b1);
        end else if (c == ChBackslash) phase_q = PH_ESC;
        else push_result(c, KIND_BYTE, 1'b1);
      end
      PH_ESC: begin
        if (it.input_end) raise_error();
        else begin
          case (c)
            ChQuote, ChBackslash, ChSlash: escape_to(c);
            ChLowerB: escape_to(ChBackspace);
            ChLowerF: escape_to(ChFormFeed);
            ChLowerN: escape_to(ChLineFeed);
            ChLowerR: escape_to(ChReturn);
            ChLowerT: escape_to(ChTab);
            ChLowerU: begin
              phase_q      = PH_HEX;
              code_point_q = '0;
              hex_count_q  = '0;
            end
            default: raise_error();
          endcase
        end
      end
      PH_HEX: begin
        digit = hex_digit_value(c);
        if (it.input_end || digit == NotHex) raise_error();
        else if (hex_count_q != 2'd3) begin
          code_point_q = {code_point_q[11:0], digit[3:0]};
          hex_count_q  = hex_count_q + 2'd1;
        end else begin
          // fourth digit: emit the code point as utf-8
          cp           = {code_point_q[11:0], digit[3:0]};
          phase_q      = PH_STR;
          code_point_q = '0;
          hex_count_q  = '0;
          if (cp < 16'h0080) begin
            push_result(cp[7:0], KIND_BYTE, 1'b1);
          end else if (cp < 16'h0800) begin
            push_result({3'b110, cp[10:6]}, KIND_BYTE, 1'b0);
            push_result({2'b10, cp[5:0]}, KIND_BYTE, 1'b1);
          end else begin
            push_result({4'b1110, cp[15:12]}, KIND_BYTE, 1'b0);
            push_result({2'b10, cp[11:6]}, KIND_BYTE, 1'b0);
            push_result({2'b10, cp[5:0]}, KIND_BYTE, 1'b1);
          end
        end
      end
      default: begin
        // idle, and the unused phase codes behave the same
        phase_q = PH_IDLE;
        if (!it.input_end) begin
          if (c == ChQuote) phase_q = PH_STR;
          else push_result(8'h00, KIND_ERROR, 1'b1);
        end
      end
    endcase
  endtask

  // compare result items, then decode the accepted input item
  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    if (!rst_ni) begin
      phase_q      = PH_IDLE;
      code_point_q = '0;
      hex_count_q  = '0;
      decoded_q.delete();
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (decoded_q.size() == 0) begin
          $error("result item with nothing outstanding: out_byte %h kind %0d last_of_run %b",
                 out_data_i.out_byte, out_data_i.kind, out_data_i.last_of_run);
          fails++;
        end else begin
          want = decoded_q.pop_front();
          if (out_data_i.out_byte !== want.out_byte) begin
            $error("out_byte mismatch: expected %h, actual %h", want.out_byte,
                   out_data_i.out_byte);
            fails++;
          end
          if (out_data_i.kind !== want.kind) begin
            $error("kind mismatch: expected %0d, actual %0d", want.kind, out_data_i.kind);
            fails++;
          end
          if (out_data_i.last_of_run !== want.last_of_run) begin
            $error("last_of_run mismatch: expected %b, actual %b", want.last_of_run,
                   out_data_i.last_of_run);
            fails++;
          end
        end
      end
      if (in_valid_i && in_ready_i) decode_item(in_data_i);
    end
    fail_count_o <= fails;
    pending_o    <= decoded_q.size();
  end

endmodule

// File: bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// Top level for the JSON string unescaper: drives well-formed string literals
// with random content, broken literals and noise bytes, with random gaps on
// the input and random stalls on the output, and reports the verdict of the
// result checker.
// ----------------------------------------------------------------------------
module tb;
  import jsu_pkg::*;
  import jsu_tb_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ItemTarget  = 410;
  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned DrainCycles = 10;

  // code points at the edges of the utf-8 length classes
  localparam logic [5:0][15:0] BoundaryPoints = {
    16'h0000, 16'h007F, 16'h0080, 16'h07FF, 16'h0800, 16'hFFFF
  };

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid;
  logic        in_ready;
  in_item_t    in_data;
  logic        out_valid;
  logic        out_ready;
  out_item_t   out_data;
  int          fail_count;
  int          pending;
  int unsigned cycle_count = 0;
  int unsigned sent_count  = 0;
  int unsigned calm_left   = 0;

  json_string_unescape_utf8 i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  jsu_result_checker i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_data_i   (out_data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // watchdog
  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Test completed with failures");
    $finish;
  end

  // idle length: mostly none or short, now and then long
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // output stalls, with occasional long stretches of steady ready
  initial begin
    int unsigned hold;
    out_ready = 1'b0;
    @(negedge clk_i);
    forever begin
      if ($urandom_range(0, 39) == 0) hold = $urandom_range(100, 300);
      else hold = $urandom_range(1, 8);
      out_ready <= 1'b1;
      repeat (hold) @(negedge clk_i);
      hold = pick_gap();
      if (hold > 0) begin
        out_ready <= 1'b0;
        repeat (hold) @(negedge clk_i);
      end
    end
  end

  // one input item, starting and ending at a falling edge
  task automatic send_item(in_item_t it);
    int unsigned gap;
    sent_count++;
    if (calm_left > 0) begin
      calm_left--;
      gap = 0;
    end else begin
      if ($urandom_range(0, 59) == 0) calm_left = $urandom_range(30, 90);
      gap = pick_gap();
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk_i); while (!in_ready);
    @(negedge clk_i);
  endtask

  task automatic send_byte(logic [7:0] b);
    in_item_t it;
    it.in_byte   = b;
    it.input_end = 1'b0;
    send_item(it);
  endtask

  // end of text; the byte lane carries junk
  task automatic send_end();
    in_item_t it;
    it.in_byte   = 8'($urandom);
    it.input_end = 1'b1;
    send_item(it);
  endtask

  // hex digit character, letters in a random case
  function automatic logic [7:0] hex_char(logic [3:0] v);
    if (v < 4'd10) return Ch0 + {4'd0, v};
    if ($urandom_range(0, 1) == 0) return ChLowerA + {4'd0, v - 4'd10};
    return ChUpperA + {4'd0, v - 4'd10};
  endfunction

  task automatic send_unicode(logic [15:0] cp);
    send_byte(ChBackslash);
    send_byte(ChLowerU);
    send_byte(hex_char(cp[15:12]));
    send_byte(hex_char(cp[11:8]));
    send_byte(hex_char(cp[7:4]));
    send_byte(hex_char(cp[3:0]));
  endtask

  // a broken tail inside a string; the block is idle afterwards
  task automatic send_fault();
    logic [7:0]  b;
    int unsigned sel;
    sel = $urandom_range(0, 4);
    case (sel)
      0: send_end();
      1: begin
        send_byte(ChBackslash);
        do b = 8'($urandom);
        while (b == ChQuote || b == ChBackslash || b == ChSlash || b == ChLowerB ||
               b == ChLowerF || b == ChLowerN || b == ChLowerR || b == ChLowerT ||
               b == ChLowerU);
        send_byte(b);
      end
      2: begin
        send_byte(ChBackslash);
        send_end();
      end
      default: begin
        send_byte(ChBackslash);
        send_byte(ChLowerU);
        repeat ($urandom_range(0, 3)) send_byte(hex_char(4'($urandom)));
        if (sel == 3) begin
          do b = 8'($urandom);
          while ((b >= Ch0 && b <= Ch9) || (b >= ChLowerA && b <= ChLowerF) ||
                 (b >= ChUpperA && b <= ChUpperF));
          send_byte(b);
        end else begin
          send_end();
        end
      end
    endcase
  endtask

  // a string literal of random parts, sometimes cut short by a fault
  task automatic send_random_string();
    int unsigned parts;
    int unsigned fault_at;
    logic [7:0]  b;
    logic [15:0] cp;
    parts    = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 24) : $urandom_range(0, 8);
    fault_at = ($urandom_range(0, 7) == 0) ? $urandom_range(0, parts) : parts + 1;
    send_byte(ChQuote);
    for (int unsigned p = 0; p < parts + 1; p++) begin
      if (p == fault_at) begin
        send_fault();
        return;
      end
      if (p < parts) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4: begin
            do b = 8'($urandom);
            while (b == ChQuote || b == ChBackslash);
            send_byte(b);
          end
          5, 6: begin
            send_byte(ChBackslash);
            send_byte(SimpleEscapes[$urandom_range(0, 7)]);
          end
          default: begin
            case ($urandom_range(0, 4))
              0: cp = 16'($urandom_range(0, 'h7F));
              1: cp = 16'($urandom_range('h80, 'h7FF));
              2: cp = 16'($urandom_range('h800, 'hFFFF));
              3: cp = 16'($urandom_range('hD800, 'hDFFF));
              default: cp = BoundaryPoints[$urandom_range(0, 5)];
            endcase
            send_unicode(cp);
          end
        endcase
      end
    end
    send_byte(ChQuote);
  endtask

  // bytes and ends of text wherever the decoder happens to be
  task automatic send_noise();
    repeat ($urandom_range(1, 3)) begin
      if ($urandom_range(0, 5) == 0) send_end();
      else send_byte(8'($urandom));
    end
  endtask

  // reset, directed items, random items, drain and verdict
  initial begin
    rst_ni   = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // idle: end of text is ignored, a stray byte is an error
    send_end();
    send_byte(8'h41);
    // string with byte extremes, an escape, a surrogate and a two-byte code point
    send_byte(ChQuote);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(ChBackslash);
    send_byte(ChLowerT);
    send_unicode(16'hD83D);
    send_unicode(16'h07FF);
    send_byte(ChQuote);
    // unknown escape letter
    send_byte(ChQuote);
    send_byte(ChBackslash);
    send_byte(8'h71);
    // non-hex byte among the digits
    send_byte(ChQuote);
    send_byte(ChBackslash);
    send_byte(ChLowerU);
    send_byte(Ch0 + 8'd1);
    send_byte(8'h47);
    // text runs out inside the string
    send_byte(ChQuote);
    send_end();

    while (sent_count < ItemTarget) begin
      if ($urandom_range(0, 9) < 8) send_random_string();
      else send_noise();
    end
    in_valid <= 1'b0;

    while (pending != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// File: json_string_unescape_utf8.f
src/jsu_pkg.sv
src/jsu_front.sv
src/jsu_fifo.sv
src/jsu_back.sv
src/json_string_unescape_utf8.sv
bench/jsu_tb_pkg.sv
bench/jsu_result_checker.sv
bench/tb.sv
